>>> rtl/bfha_pkg.sv
`timescale 1ns / 1ps
package bfha_pkg;
  localparam int ARENA_BYTES = 65536;
  localparam int UNIT_BYTES  = 16;
  localparam int UNITS       = ARENA_BYTES / UNIT_BYTES;
  localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);
  localparam int IDX_W       = $clog2(UNITS + 1);
  localparam int LIVE_W      = $clog2(UNITS);
  localparam logic [IDX_W-1:0] SENTINEL = IDX_W'(UNITS);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  function automatic idx_t clip(input logic [IDX_W:0] x);
    return (x <= {1'b0, SENTINEL}) ? x[IDX_W-1:0] : SENTINEL;
  endfunction
endpackage

>>> rtl/best_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
// An exact-fit allocate answers at the end of the free-list walk, a carved one after a carve
// step, a free after the in-use check, the walk and the next and previous link-and-merge steps.
// Free-list headers are read one per cycle through the read port of the header memories. A
// rejected free is answered from idle (address 0) or from the in-use check. One transaction at
// a time; busy is high while it runs, and the next one can be taken in the cycle out_valid is
// shown. The receiver cannot stall. After synchronous reset (rst_n low) an init pass over every
// unit clears the in-use bits and sets up the arena; busy stays high during it.
module best_fit_heap_allocator_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_opcode,
  input  logic [15:0]                in_request_bytes,
  input  logic [11:0]                in_block_address,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [11:0]                out_payload_address,
  output logic [12:0]                out_units_in_use
);
  import bfha_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_A_HEAD, S_A_WALK, S_A_CARVE, S_F_CHK, S_F_WALK, S_F_NX, S_F_P
  } state_t;

  logic [IDX_W-1:0] next_mem [0:UNITS];
  logic [IDX_W-1:0] size_mem [0:UNITS];
  logic             live_mem [0:UNITS-1];

  idx_t              rd_addr, wa, wd_next, wd_size, nq, sq;
  logic              we_next, we_size;
  logic [LIVE_W-1:0] laddr;
  logic              lwe, ldata, lq;

  always_ff @(posedge clk) begin
    if (we_next) next_mem[wa] <= wd_next;
    if (we_size) size_mem[wa] <= wd_size;
    nq <= next_mem[rd_addr];
    sq <= size_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (lwe) live_mem[laddr] <= ldata;
    lq <= live_mem[laddr];
  end

  state_t            state_r, state_nxt;
  logic [LIVE_W-1:0] cnt_r, cnt_nxt;
  idx_t rover_r, rover_nxt, used_r, used_nxt, need_r, need_nxt;
  idx_t prev_r, prev_nxt, cur_r, cur_nxt, best_r, best_nxt, bsize_r, bsize_nxt;
  idx_t bprev_r, bprev_nxt, bp_r, bp_nxt, bpsize_r, bpsize_nxt;
  idx_t p_r, p_nxt, psize_r, psize_nxt, nx_r, nx_nxt;
  logic have_r, have_nxt;
  logic valid_r, valid_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [11:0] pay_r, pay_nxt;
  logic [12:0] units_r, units_nxt;

  logic [16:0]      bytes_sum;
  logic             upd, have_e, brk, merge;
  idx_t             best_e, bsize_e, bprev_e, nsize, nxc;
  logic [IDX_W:0]   sum;

  always_comb begin
    state_nxt = state_r;   cnt_nxt = cnt_r;     rover_nxt = rover_r; used_nxt = used_r;
    need_nxt = need_r;     prev_nxt = prev_r;   cur_nxt = cur_r;     best_nxt = best_r;
    bsize_nxt = bsize_r;   bprev_nxt = bprev_r; bp_nxt = bp_r;       bpsize_nxt = bpsize_r;
    p_nxt = p_r;           psize_nxt = psize_r; nx_nxt = nx_r;       have_nxt = have_r;
    valid_nxt = 1'b0;      status_nxt = status_r; pay_nxt = pay_r;   units_nxt = units_r;
    rd_addr = rover_r;     wa = rover_r;        wd_next = '0;        wd_size = '0;
    we_next = 1'b0;        we_size = 1'b0;
    laddr = bp_r[LIVE_W-1:0]; lwe = 1'b0;       ldata = 1'b0;
    bytes_sum = '0; upd = 1'b0; have_e = have_r; best_e = best_r; bsize_e = bsize_r;
    bprev_e = bprev_r; nsize = '0; nxc = '0; sum = '0; brk = 1'b0; merge = 1'b0;

    unique case (state_r)
      S_INIT: begin
        laddr = cnt_r; lwe = 1'b1; ldata = 1'b0;
        if (cnt_r == '0) begin
          wa = '0; wd_next = SENTINEL; wd_size = SENTINEL; we_next = 1'b1; we_size = 1'b1;
        end else if (cnt_r == LIVE_W'(1)) begin
          wa = SENTINEL; wd_next = '0; wd_size = '0; we_next = 1'b1; we_size = 1'b1;
        end
        cnt_nxt = cnt_r + LIVE_W'(1);
        if (cnt_r == LIVE_W'(UNITS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (in_opcode == OP_ALLOC) begin
            bytes_sum = (in_request_bytes == '0) ? 17'd1 : {1'b0, in_request_bytes};
            bytes_sum = bytes_sum + 17'(UNIT_BYTES - 1);
            need_nxt  = IDX_W'(bytes_sum >> UNIT_SHIFT) + IDX_W'(1);
            prev_nxt  = rover_r;
            rd_addr   = rover_r;
            have_nxt  = 1'b0;
            state_nxt = S_A_HEAD;
          end else if (in_block_address == '0) begin
            valid_nxt = 1'b1; status_nxt = ST_BAD_FREE; pay_nxt = '0; units_nxt = used_r;
          end else begin
            bp_nxt    = IDX_W'(in_block_address - 12'd1);
            laddr     = LIVE_W'(in_block_address - 12'd1);
            rd_addr   = IDX_W'(in_block_address - 12'd1);
            state_nxt = S_F_CHK;
          end
        end
      end
      S_A_HEAD: begin
        cur_nxt   = clip({1'b0, nq});
        rd_addr   = cur_nxt;
        state_nxt = S_A_WALK;
      end
      S_A_WALK: begin
        if (sq == need_r) begin
          wa = prev_r; wd_next = nq; we_next = 1'b1;
          laddr = cur_r[LIVE_W-1:0]; lwe = (cur_r < SENTINEL); ldata = 1'b1;
          rover_nxt = prev_r;
          used_nxt  = used_r + need_r;
          valid_nxt = 1'b1; status_nxt = ST_OK;
          pay_nxt   = 12'(cur_r + IDX_W'(1)); units_nxt = used_nxt;
          state_nxt = S_IDLE;
        end else begin
          upd = (sq > need_r) && (!have_r || bsize_r > sq);
          if (upd) begin
            have_e = 1'b1; best_e = cur_r; bsize_e = sq; bprev_e = prev_r;
          end
          have_nxt = have_e; best_nxt = best_e; bsize_nxt = bsize_e; bprev_nxt = bprev_e;
          if (cur_r == rover_r) begin
            if (!have_e) begin
              valid_nxt = 1'b1; status_nxt = ST_NO_FIT; pay_nxt = '0; units_nxt = used_r;
              state_nxt = S_IDLE;
            end else begin
              // carve from the tail: shrink best, header of new block sits past it
              nsize = bsize_e - need_r;
              wa = best_e; wd_size = nsize; we_size = 1'b1;
              cur_nxt   = clip({1'b0, best_e} + {1'b0, nsize});
              state_nxt = S_A_CARVE;
            end
          end else begin
            prev_nxt = cur_r;
            cur_nxt  = clip({1'b0, nq});
            rd_addr  = cur_nxt;
          end
        end
      end
      S_A_CARVE: begin
        wa = cur_r; wd_size = need_r; we_size = 1'b1;
        laddr = cur_r[LIVE_W-1:0]; lwe = (cur_r < SENTINEL); ldata = 1'b1;
        rover_nxt = bprev_r;
        used_nxt  = used_r + need_r;
        valid_nxt = 1'b1; status_nxt = ST_OK;
        pay_nxt   = 12'(cur_r + IDX_W'(1)); units_nxt = used_nxt;
        state_nxt = S_IDLE;
      end
      S_F_CHK: begin
        if (!lq) begin
          valid_nxt = 1'b1; status_nxt = ST_BAD_FREE; pay_nxt = '0; units_nxt = used_r;
          state_nxt = S_IDLE;
        end else begin
          lwe = 1'b1; ldata = 1'b0;
          bpsize_nxt = sq;
          used_nxt   = (used_r >= sq) ? used_r - sq : '0;
          p_nxt      = rover_r;
          rd_addr    = rover_r;
          state_nxt  = S_F_WALK;
        end
      end
      S_F_WALK: begin
        nxc = clip({1'b0, nq});
        brk = (bp_r > p_r && bp_r < nxc) || (p_r >= nxc && (bp_r > p_r || bp_r < nxc));
        rd_addr = nxc;
        if (brk) begin
          psize_nxt = sq; nx_nxt = nxc; state_nxt = S_F_NX;
        end else begin
          p_nxt = nxc;
        end
      end
      S_F_NX: begin
        sum   = {1'b0, bp_r} + {1'b0, bpsize_r};
        merge = (nx_r != SENTINEL) && (sum == {1'b0, nx_r});
        wa = bp_r; we_next = 1'b1; we_size = 1'b1;
        wd_size = merge ? bpsize_r + sq : bpsize_r;
        wd_next = merge ? nq : nx_r;
        bpsize_nxt = wd_size;
        nx_nxt     = wd_next;
        state_nxt  = S_F_P;
      end
      S_F_P: begin
        sum   = {1'b0, p_r} + {1'b0, psize_r};
        merge = (p_r != SENTINEL) && (sum == {1'b0, bp_r});
        wa = p_r; we_next = 1'b1; we_size = 1'b1;
        wd_size = merge ? psize_r + bpsize_r : psize_r;
        wd_next = merge ? nx_r : bp_r;
        rover_nxt = p_r;
        valid_nxt = 1'b1; status_nxt = ST_OK; pay_nxt = '0; units_nxt = used_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; cnt_r <= '0; rover_r <= SENTINEL; used_r <= '0;
      have_r <= 1'b0; valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; rover_r <= rover_nxt; used_r <= used_nxt;
      have_r <= have_nxt; valid_r <= valid_nxt;
    end
    need_r <= need_nxt; prev_r <= prev_nxt; cur_r <= cur_nxt; best_r <= best_nxt;
    bsize_r <= bsize_nxt; bprev_r <= bprev_nxt; bp_r <= bp_nxt; bpsize_r <= bpsize_nxt;
    p_r <= p_nxt; psize_r <= psize_nxt; nx_r <= nx_nxt;
    status_r <= status_nxt; pay_r <= pay_nxt; units_r <= units_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = valid_r;
  assign out_status          = status_r;
  assign out_payload_address = pay_r;
  assign out_units_in_use    = units_r;
endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import bfha_pkg::*;

  localparam int CYCLE_LIMIT = 12_000_000;

  class heap_scoreboard;
    int hdr_next[UNITS+1];
    int hdr_size[UNITS+1];
    bit in_use[UNITS];
    int rover;
    int used;
    int live_blocks[$];
    logic [1:0]  exp_status[$];
    logic [11:0] exp_payload[$];
    logic [12:0] exp_units[$];
    int mismatches;
    int checked;

    function new();
      for (int i = 0; i <= UNITS; i++) begin
        hdr_next[i] = 0;
        hdr_size[i] = 0;
      end
      for (int i = 0; i < UNITS; i++) in_use[i] = 0;
      hdr_next[0] = UNITS;
      hdr_size[0] = UNITS;
      hdr_next[UNITS] = 0;
      rover = UNITS;
      used = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function int clamp(int x);
      return (x <= UNITS) ? x : UNITS;
    endfunction

    function status_t do_alloc(int req, output int payload);
      int bytes, need, prev, cur, sz, best, bprev, hdr;
      bit have;
      bytes = (req != 0) ? req : 1;
      need = (bytes + UNIT_BYTES - 1) / UNIT_BYTES + 1;
      prev = clamp(rover);
      cur = clamp(hdr_next[prev]);
      have = 0;
      best = 0;
      bprev = 0;
      payload = 0;
      for (int steps = 0; steps <= UNITS + 1; steps++) begin
        sz = hdr_size[cur];
        if (sz == need) begin
          hdr_next[prev] = hdr_next[cur];
          rover = prev;
          if (cur < UNITS) in_use[cur] = 1;
          used += need;
          payload = cur + 1;
          return ST_OK;
        end
        if (sz > need && (!have || hdr_size[best] > sz)) begin
          have = 1;
          best = cur;
          bprev = prev;
        end
        if (cur == rover) break;
        prev = cur;
        cur = clamp(hdr_next[cur]);
      end
      if (!have) return ST_NO_FIT;
      hdr_size[best] -= need;
      hdr = clamp(best + hdr_size[best]);
      hdr_size[hdr] = need;
      if (hdr < UNITS) in_use[hdr] = 1;
      rover = bprev;
      used += need;
      payload = hdr + 1;
      return ST_OK;
    endfunction

    function status_t do_free(int addr);
      int bp, p, nx;
      if (addr == 0 || addr >= UNITS) return ST_BAD_FREE;
      bp = addr - 1;
      if (!in_use[bp]) return ST_BAD_FREE;
      in_use[bp] = 0;
      used = (used >= hdr_size[bp]) ? used - hdr_size[bp] : 0;
      p = clamp(rover);
      for (int steps = 0; steps <= UNITS + 1; steps++) begin
        nx = clamp(hdr_next[p]);
        if (bp > p && bp < nx) break;
        if (p >= nx && (bp > p || bp < nx)) break;
        p = nx;
      end
      nx = clamp(hdr_next[p]);
      if (nx != UNITS && bp + hdr_size[bp] == nx) begin
        hdr_size[bp] += hdr_size[nx];
        hdr_next[bp] = hdr_next[nx];
      end else begin
        hdr_next[bp] = nx;
      end
      if (p != UNITS && p + hdr_size[p] == bp) begin
        hdr_size[p] += hdr_size[bp];
        hdr_next[p] = hdr_next[bp];
      end else begin
        hdr_next[p] = bp;
      end
      rover = p;
      return ST_OK;
    endfunction

    function void note_request(logic op, logic [15:0] req, logic [11:0] addr);
      status_t st;
      int payload;
      payload = 0;
      if (op == OP_ALLOC) begin
        st = do_alloc(int'(req), payload);
        if (st == ST_OK) live_blocks.push_back(payload);
      end else begin
        st = do_free(int'(addr));
        if (st == ST_OK)
          foreach (live_blocks[i])
            if (live_blocks[i] == int'(addr)) begin
              live_blocks.delete(i);
              break;
            end
      end
      exp_status.push_back(st);
      exp_payload.push_back(payload[11:0]);
      exp_units.push_back(used[12:0]);
    endfunction

    function void check_result(logic [1:0] st, logic [11:0] pa, logic [12:0] uu);
      logic [1:0]  es;
      logic [11:0] ep;
      logic [12:0] eu;
      if (exp_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d payload %0d units %0d",
                                       st, pa, uu);
        return;
      end
      es = exp_status.pop_front();
      ep = exp_payload.pop_front();
      eu = exp_units.pop_front();
      checked++;
      if (st !== es || pa !== ep || uu !== eu) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: exp status %0d payload %0d units %0d, got %0d %0d %0d",
                   checked, es, ep, eu, st, pa, uu);
      end
    endfunction

    function int pending();
      return exp_status.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_opcode = 0;
  logic [15:0] in_request_bytes = 0;
  logic [11:0] in_block_address = 0;
  logic out_valid;
  logic [1:0] out_status;
  logic [11:0] out_payload_address;
  logic [12:0] out_units_in_use;

  heap_scoreboard sb = new();
  int cycles = 0;
  int idle_pct = 0;
  int n_alloc = 0, n_free = 0, n_bad = 0;

  always #5 clk = ~clk;

  best_fit_heap_allocator_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_request_bytes(in_request_bytes),
    .in_block_address(in_block_address), .out_valid(out_valid),
    .out_status(out_status), .out_payload_address(out_payload_address),
    .out_units_in_use(out_units_in_use)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n && start && !busy) sb.note_request(in_opcode, in_request_bytes, in_block_address);
    if (rst_n && out_valid) sb.check_result(out_status, out_payload_address, out_units_in_use);
  end

  // start stays high from one transaction to the next unless a gap is drawn
  task automatic issue(logic op, logic [15:0] req, logic [11:0] addr);
    @(negedge clk);
    in_opcode <= op;
    in_request_bytes <= req;
    in_block_address <= addr;
    start <= 1;
    do @(posedge clk); while (busy);
    if (op == OP_ALLOC) n_alloc++; else n_free++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic alloc(logic [15:0] req);
    issue(OP_ALLOC, req, 12'($urandom));
  endtask

  task automatic release_blk(logic [11:0] addr);
    issue(OP_FREE, 16'($urandom), addr);
  endtask

  task automatic release_live();
    int k;
    k = $urandom_range(sb.live_blocks.size() - 1);
    release_blk(12'(sb.live_blocks[k]));
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (sb.live_blocks.size() > 0 && (r < 35 || (sb.used > 3000 && r < 70))) begin
      release_live();
    end else if (r >= 93) begin
      n_bad++;
      case ($urandom_range(3))
        0: release_blk(12'd0);
        1: release_blk(12'hFFF);
        default: release_blk(12'($urandom));
      endcase
    end else if (r >= 88) begin
      alloc(16'($urandom));
    end else begin
      alloc(16'($urandom_range(0, 400)));
    end
  endtask

  initial begin
    int a, b, c;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: whole arena exact fit, no-fit cases, bad and double frees, merges
    alloc(16'd65519);
    alloc(16'd0);
    release_blk(12'd1);
    alloc(16'hFFFF);
    release_blk(12'd1);
    release_blk(12'd0);
    release_blk(12'hFFF);
    release_blk(12'hAAA);
    release_blk(12'h555);
    alloc(16'd0);
    alloc(16'd16);
    alloc(16'd17);
    alloc(16'd1000);
    alloc(16'd32);
    drain();
    a = sb.live_blocks[1];
    b = sb.live_blocks[2];
    c = sb.live_blocks[3];
    release_blk(12'(a));
    release_blk(12'(c));
    release_blk(12'(b));
    release_blk(12'(b));
    alloc(16'd48);
    alloc(16'd60000);
    alloc(16'd65535);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 78;
        2: idle_pct = 0;
        default: idle_pct = 18;
      endcase
      for (int i = 0; i < 232; i++) begin
        random_item();
        if (i == 100) drain();
      end
    end
    // return everything, then check the arena is whole again
    while (sb.live_blocks.size() > 0) release_live();
    alloc(16'd65519);

    drain();
    repeat (200) @(negedge clk);
    $display("ran %0d allocates and %0d frees (%0d deliberately bad), %0d results checked",
             n_alloc, n_free, n_bad, sb.checked);
    $display("%0d mismatches, %0d expectations left", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/bfha_pkg.sv
rtl/best_fit_heap_allocator_top.sv
dv/tb.sv
